### rtl/square_matrix_multiply_top_macros.svh
// Assertion helpers for the matrix multiplier checker.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define SMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/smm_pkg.sv
package smm_pkg;

    localparam int ELEM_W      = 16;  // input element
    localparam int MUL_W       = 2 * ELEM_W;
    localparam int PROD_W      = 35;  // product element, exact for dimension up to 8
    localparam int IDX_W       = 3;   // row and column index
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PROD_W - 2 * IDX_W;

    // controller to datapath
    typedef struct packed {
        logic wr_en;     // store the incoming element
        logic wr_sel;    // 0: left matrix, 1: right matrix
        logic rd_en;     // issue one multiply-accumulate step
        logic rd_first;  // first term of a dot product
        logic rd_last;   // last term of a dot product
        logic load_out;  // move the finished sum to the output register
        logic out_last;  // final element of the product matrix
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic acc_valid; // accumulator holds a complete dot product
        logic out_free;  // output register can take a value this cycle
    } t_dp_status;

endpackage

### rtl/smm_ctrl.sv
module smm_ctrl #(
    parameter int MATRIX_DIM = 3,
    parameter int ADDR_W     = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  smm_pkg::t_dp_status      i_status,
    output smm_pkg::t_dp_cmd         o_cmd,
    output logic [ADDR_W-1:0]        o_wr_addr,
    output logic [ADDR_W-1:0]        o_rd_a_addr,
    output logic [ADDR_W-1:0]        o_rd_b_addr,
    output logic [smm_pkg::IDX_W-1:0] o_row,
    output logic [smm_pkg::IDX_W-1:0] o_col
);

    localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
    localparam logic [smm_pkg::IDX_W-1:0] LAST_IDX = smm_pkg::IDX_W'(MATRIX_DIM - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] DIM_STEP  = ADDR_W'(MATRIX_DIM);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_in_ready, n_in_ready;
    logic [ADDR_W-1:0]         r_wr_addr, n_wr_addr;
    logic                      r_wr_sel, n_wr_sel;
    logic [smm_pkg::IDX_W-1:0] r_row, n_row;
    logic [smm_pkg::IDX_W-1:0] r_col, n_col;
    logic [smm_pkg::IDX_W-1:0] r_k, n_k;
    logic [ADDR_W-1:0]         r_row_base, n_row_base;
    logic [ADDR_W-1:0]         r_a_addr, n_a_addr;
    logic [ADDR_W-1:0]         r_b_addr, n_b_addr;
    smm_pkg::t_dp_cmd          cmd;
    logic                      accept;
    logic                      last_cell;

    assign accept    = i_in_valid && r_in_ready;
    assign last_cell = (r_row == LAST_IDX) && (r_col == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        n_wr_addr  = r_wr_addr;
        n_wr_sel   = r_wr_sel;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_row_base = r_row_base;
        n_a_addr   = r_a_addr;
        n_b_addr   = r_b_addr;
        cmd        = '0;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = r_wr_sel;
                    if (r_wr_addr == LAST_CELL) begin
                        n_wr_addr = '0;
                        n_wr_sel  = ~r_wr_sel;
                        if (r_wr_sel) begin
                            // both matrices loaded
                            n_state    = S_ISSUE;
                            n_in_ready = 1'b0;
                            n_row      = '0;
                            n_col      = '0;
                            n_k        = '0;
                            n_row_base = '0;
                            n_a_addr   = '0;
                            n_b_addr   = '0;
                        end
                    end else begin
                        n_wr_addr = r_wr_addr + ADDR_W'(1);
                    end
                end
            end
            S_ISSUE: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (r_k == '0);
                cmd.rd_last  = (r_k == LAST_IDX);
                if (r_k == LAST_IDX) begin
                    n_state = S_WAIT;
                    n_k     = '0;
                end else begin
                    n_k      = r_k + smm_pkg::IDX_W'(1);
                    n_a_addr = r_a_addr + ADDR_W'(1);
                    n_b_addr = r_b_addr + DIM_STEP;
                end
            end
            S_WAIT: begin
                if (i_status.acc_valid && i_status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = last_cell;
                    if (last_cell) begin
                        n_state    = S_LOAD;
                        n_in_ready = 1'b1;
                    end else begin
                        n_state = S_ISSUE;
                        if (r_col == LAST_IDX) begin
                            n_col      = '0;
                            n_row      = r_row + smm_pkg::IDX_W'(1);
                            n_row_base = r_row_base + DIM_STEP;
                            n_a_addr   = r_row_base + DIM_STEP;
                            n_b_addr   = '0;
                        end else begin
                            n_col    = r_col + smm_pkg::IDX_W'(1);
                            n_a_addr = r_row_base;
                            n_b_addr = ADDR_W'(r_col) + ADDR_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state    = S_LOAD;
                n_in_ready = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_in_ready <= 1'b1;
            r_wr_addr  <= '0;
            r_wr_sel   <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
            r_row_base <= '0;
            r_a_addr   <= '0;
            r_b_addr   <= '0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
            r_wr_addr  <= n_wr_addr;
            r_wr_sel   <= n_wr_sel;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
            r_row_base <= n_row_base;
            r_a_addr   <= n_a_addr;
            r_b_addr   <= n_b_addr;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_cmd       = cmd;
    assign o_wr_addr   = r_wr_addr;
    assign o_rd_a_addr = r_a_addr;
    assign o_rd_b_addr = r_b_addr;
    assign o_row       = r_row;
    assign o_col       = r_col;

endmodule

### rtl/smm_datapath.sv
module smm_datapath #(
    parameter int MATRIX_DIM = 3,
    parameter int ADDR_W     = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smm_pkg::t_dp_cmd                  i_cmd,
    output smm_pkg::t_dp_status               o_status,
    input  logic [smm_pkg::ELEM_W-1:0]        i_elem,
    input  logic [ADDR_W-1:0]                 i_wr_addr,
    input  logic [ADDR_W-1:0]                 i_rd_a_addr,
    input  logic [ADDR_W-1:0]                 i_rd_b_addr,
    input  logic [smm_pkg::IDX_W-1:0]         i_row,
    input  logic [smm_pkg::IDX_W-1:0]         i_col,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [smm_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic                              o_out_last
);

    localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
    localparam int EXT_W = smm_pkg::PROD_W - smm_pkg::MUL_W;

    logic signed [smm_pkg::ELEM_W-1:0] mem_a [CELLS];
    logic signed [smm_pkg::ELEM_W-1:0] mem_b [CELLS];

    logic signed [smm_pkg::ELEM_W-1:0] r_a_q, r_b_q;
    logic signed [smm_pkg::MUL_W-1:0]  r_prod;
    logic signed [smm_pkg::PROD_W-1:0] r_acc;
    logic        [smm_pkg::PROD_W-1:0] r_out_value;
    logic        [smm_pkg::IDX_W-1:0]  r_out_row, r_out_col;
    logic                              r_out_last;
    logic                              r_v1, r_first1, r_last1;
    logic                              r_v2, r_first2, r_last2;
    logic                              r_acc_valid;
    logic                              r_out_valid;
    logic signed [smm_pkg::PROD_W-1:0] prod_ext;
    logic                              out_free;

    // element stores, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && !i_cmd.wr_sel) begin
            mem_a[i_wr_addr] <= i_elem;
        end
        r_a_q <= mem_a[i_rd_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_cmd.wr_sel) begin
            mem_b[i_wr_addr] <= i_elem;
        end
        r_b_q <= mem_b[i_rd_b_addr];
    end

    assign prod_ext = {{EXT_W{r_prod[smm_pkg::MUL_W-1]}}, r_prod};
    assign out_free = !r_out_valid || i_out_ready;

    // read -> multiply -> accumulate
    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.rd_first;
        r_last1  <= i_cmd.rd_last;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_prod   <= r_a_q * r_b_q;
        if (r_v2) begin
            r_acc <= r_first2 ? prod_ext : r_acc + prod_ext;
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_acc;
            r_out_row   <= i_row;
            r_out_col   <= i_col;
            r_out_last  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            if (i_cmd.load_out) begin
                r_acc_valid <= 1'b0;
            end else if (r_v2 && r_last2) begin
                r_acc_valid <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.acc_valid = r_acc_valid;
    assign o_status.out_free  = out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {{smm_pkg::OUT_PAD_W{1'b0}}, r_out_col, r_out_row, r_out_value};
    assign o_out_last  = r_out_last;

endmodule

### rtl/square_matrix_multiply_top.sv
// Channel    Dir  Payload (tdata from bit 0 up)                        Marker
// s_axis     in   element_value[15:0]                                  -
// m_axis     out  product_value[34:0], out_row[37:35], out_col[40:38]  tlast = last_element
//
// Loading takes one element per cycle, 2*N*N elements, A then B, row-major.
// Each product element takes N steps through the single 16x16 multiplier,
// then passes the store read, multiply and accumulate registers.
// No element is taken while the N*N products are formed; the output register
// frees the next load while the final product is still waiting.
// Synchronous active-low reset; stores need no clearing. A stalled output holds.
module square_matrix_multiply_top #(
    parameter int MATRIX_DIM = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [smm_pkg::ELEM_W-1:0]      i_s_axis_tdata,  // element_value
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [smm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // product_value, out_row, out_col
    output logic                            o_m_axis_tlast
);

    localparam int ADDR_W = $clog2(MATRIX_DIM * MATRIX_DIM);

    smm_pkg::t_dp_cmd          cmd;
    smm_pkg::t_dp_status       status;
    logic [ADDR_W-1:0]         wr_addr, rd_a_addr, rd_b_addr;
    logic [smm_pkg::IDX_W-1:0] row, col;

    smm_ctrl #(
        .MATRIX_DIM (MATRIX_DIM),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr),
        .o_row       (row),
        .o_col       (col)
    );

    smm_datapath #(
        .MATRIX_DIM (MATRIX_DIM),
        .ADDR_W     (ADDR_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_elem      (i_s_axis_tdata),
        .i_wr_addr   (wr_addr),
        .i_rd_a_addr (rd_a_addr),
        .i_rd_b_addr (rd_b_addr),
        .i_row       (row),
        .i_col       (col),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_tdata (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

### rtl/smm_checker.sv
`include "square_matrix_multiply_top_macros.svh"

module smm_checker #(
    parameter int MATRIX_DIM = 3
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_tready,
    input logic                            i_out_tvalid,
    input logic                            i_out_tready,
    input logic [smm_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    input logic                            i_out_tlast
);

    localparam logic [smm_pkg::IDX_W-1:0] LAST_IDX = smm_pkg::IDX_W'(MATRIX_DIM - 1);

    logic [smm_pkg::IDX_W-1:0] out_row, out_col;

    assign out_row = i_out_tdata[smm_pkg::PROD_W +: smm_pkg::IDX_W];
    assign out_col = i_out_tdata[smm_pkg::PROD_W + smm_pkg::IDX_W +: smm_pkg::IDX_W];

    `SMM_ASSERT_NXT(a_out_hold, i_out_tvalid && !i_out_tready, i_out_tvalid && $stable(i_out_tdata) && $stable(i_out_tlast), "stalled result changed")
    `SMM_ASSERT_IMP(a_last_corner, i_out_tvalid && i_out_tlast, out_row == LAST_IDX && out_col == LAST_IDX, "tlast away from final element")
    `SMM_ASSERT_IMP(a_idx_range, i_out_tvalid, out_row <= LAST_IDX && out_col <= LAST_IDX, "row or column beyond dimension")
    `SMM_ASSERT_IMP(a_no_load_mid_run, i_out_tvalid && !i_out_tlast, !i_in_tready, "input ready while products still pending")

endmodule

bind square_matrix_multiply_top smm_checker #(
    .MATRIX_DIM (MATRIX_DIM)
) u_smm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_tready  (o_s_axis_tready),
    .i_out_tvalid (o_m_axis_tvalid),
    .i_out_tready (i_m_axis_tready),
    .i_out_tdata  (o_m_axis_tdata),
    .i_out_tlast  (o_m_axis_tlast)
);

### tb/square_matrix_multiply_top_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own copy of the two operand matrices and
// checks every product transaction against the oldest pending product element.
module square_matrix_multiply_top_checker #(
    parameter int MATRIX_DIM = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [smm_pkg::ELEM_W-1:0]      i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [smm_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    output int                              o_mismatch_count,
    output int                              o_pending_count,
    output int                              o_checked_count
);

    localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
    localparam int ELEM_W = smm_pkg::ELEM_W;
    localparam int PROD_W = smm_pkg::PROD_W;
    localparam int IDX_W  = smm_pkg::IDX_W;

    typedef struct packed {
        logic [PROD_W-1:0] value;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
    } t_product_entry;

    logic signed [ELEM_W-1:0] left_cells  [CELLS];
    logic signed [ELEM_W-1:0] right_cells [CELLS];
    int                       load_count;
    t_product_entry           product_q [$];

    // exact dot products, truncated to the result width
    function automatic void form_product_matrix();
        t_product_entry entry;
        longint         acc;
        for (int r = 0; r < MATRIX_DIM; r++) begin
            for (int c = 0; c < MATRIX_DIM; c++) begin
                acc = 0;
                for (int k = 0; k < MATRIX_DIM; k++)
                    acc += longint'(left_cells[r * MATRIX_DIM + k]) *
                           longint'(right_cells[k * MATRIX_DIM + c]);
                entry.value = acc[PROD_W-1:0];
                entry.row   = IDX_W'(r);
                entry.col   = IDX_W'(c);
                entry.last  = (r == MATRIX_DIM - 1) && (c == MATRIX_DIM - 1);
                product_q.push_back(entry);
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_product_entry got;
        t_product_entry want;
        if (!i_rst_n) begin
            load_count       = 0;
            product_q.delete();
            o_mismatch_count = 0;
            o_checked_count  = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (load_count < CELLS)
                    left_cells[load_count] = i_s_tdata;
                else
                    right_cells[load_count - CELLS] = i_s_tdata;
                load_count++;
                if (load_count == 2 * CELLS) begin
                    form_product_matrix();
                    load_count = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[PROD_W-1:0];
                got.row   = i_m_tdata[PROD_W+IDX_W-1:PROD_W];
                got.col   = i_m_tdata[PROD_W+2*IDX_W-1:PROD_W+IDX_W];
                got.last  = i_m_tlast;
                o_checked_count++;
                if (product_q.size() == 0) begin
                    report_mismatch("unexpected product transaction", got, 0);
                end else begin
                    want = product_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("product [%0d][%0d]", want.row, want.col),
                                        got.value, want.value);
                    if (got.row !== want.row)
                        report_mismatch("row index", got.row, want.row);
                    if (got.col !== want.col)
                        report_mismatch("column index", got.col, want.col);
                    if (got.last !== want.last)
                        report_mismatch("tlast", got.last, want.last);
                end
            end
        end
        o_pending_count = product_q.size();
    end

endmodule

### tb/square_matrix_multiply_top_tb.sv
`timescale 1ns / 1ps

module square_matrix_multiply_top_tb;
    import smm_pkg::*;

    localparam int DIM          = 3;
    localparam int CELLS        = DIM * DIM;
    localparam int TARGET_ITEMS = 410;

    typedef enum int {
        FILL_DIRECTED,
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_SMALL,
        FILL_IDENT_LEFT,
        FILL_IDENT_RIGHT
    } fill_mode_e;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   s_tvalid        = 1'b0;
    logic [ELEM_W-1:0]      s_tdata         = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready        = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int elements_sent   = 0;
    int pairs_sent      = 0;
    int ready_hold      = 0;
    int ready_roll;

    square_matrix_multiply_top #(
        .MATRIX_DIM (DIM)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    square_matrix_multiply_top_checker #(
        .MATRIX_DIM (DIM)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tlast        (m_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_checked_count  (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4ms;
        $display("timeout with %0d product elements outstanding", pending_count);
        $display("square_matrix_multiply_top_tb failed");
        $finish;
    end

    // receiver back-pressure: mostly ready, short stalls, the odd long stall or long ready run
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 55) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (ready_roll < 62) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(30, 80);
            end else if (ready_roll < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element(fill_mode_e mode, int idx, bit right);
        int r;
        int c;
        r = idx / DIM;
        c = idx % DIM;
        case (mode)
            FILL_DIRECTED: begin
                // A all most-negative; B columns cycle through min, max and zero
                if (!right)
                    return 16'h8000;
                case (c % 3)
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    default: return 16'h0000;
                endcase
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            FILL_SMALL:
                return ELEM_W'($urandom_range(0, 8) - 4);
            FILL_IDENT_LEFT:
                if (!right)
                    return (r == c) ? 16'h0001 : 16'h0000;
            FILL_IDENT_RIGHT:
                if (right)
                    return (r == c) ? 16'h0001 : 16'h0000;
            default: ;
        endcase
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_element(input logic [ELEM_W-1:0] value, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        elements_sent++;
    endtask

    task automatic send_matrix_pair(input fill_mode_e mode);
        bit no_gaps;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 2 * CELLS; i++)
            send_element(pick_element(mode, i % CELLS, i >= CELLS), no_gaps);
        pairs_sent++;
    endtask

    initial begin
        int roll;
        fill_mode_e mode;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_matrix_pair(FILL_DIRECTED);

        while (elements_sent < TARGET_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll < 5)
                mode = FILL_RANDOM;
            else if (roll < 7)
                mode = FILL_EXTREME;
            else if (roll < 8)
                mode = FILL_SMALL;
            else if (roll < 9)
                mode = FILL_IDENT_LEFT;
            else
                mode = FILL_IDENT_RIGHT;
            send_matrix_pair(mode);
        end
        s_tvalid <= 1'b0;

        // sample away from the clock edge so the pending count is settled
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (4 * (DIM + 3)) @(posedge i_clk);

        $display("%0d matrix pairs loaded (%0d elements, random and extreme operands)",
                 pairs_sent, elements_sent);
        $display("%0d product transactions compared under random back-pressure",
                 checked_count);
        if (mismatch_count == 0) begin
            $display("square_matrix_multiply_top_tb passed");
        end else begin
            $display("square_matrix_multiply_top_tb failed");
        end
        $finish;
    end

endmodule
